[src/nfts_pkg.sv]
// Package with the shared types, codes and sizes of the NOR flash transaction sequencer.
`timescale 1ns / 1ps
package nfts_pkg;

  // Flash geometry in bytes.
  localparam logic [31:0] PAGE_BYTES   = 32'd256;
  localparam logic [31:0] SECTOR_BYTES = 32'd4096;
  localparam logic [31:0] BLOCK_BYTES  = 32'd65536;

  // Capacity above which the device takes 4-byte addresses.
  localparam logic [4:0] EXT_ADDR_LOG2 = 5'd24;
  localparam logic [4:0] CAP_LOG2_RST  = 5'd24;

  // Request commands.
  typedef enum logic [3:0] {
    CMD_READ      = 4'd0,
    CMD_WRITE     = 4'd1,
    CMD_ERASE_SEC = 4'd2,
    CMD_ERASE_BLK = 4'd3,
    CMD_SET_POS   = 4'd4,
    CMD_BUS_DONE  = 4'd5,
    CMD_SUSPEND   = 4'd6,
    CMD_RESUME    = 4'd7,
    CMD_STATUS    = 4'd8
  } cmd_t;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    CFG_CAP_LOG2 = 3'd0,
    CFG_QUAD     = 3'd1,
    CFG_DTR      = 3'd2,
    CFG_SHRINK   = 3'd3
  } cfg_idx_t;

  // Bus descriptor operations.
  localparam logic [4:0] OP_WREN        = 5'd0;
  localparam logic [4:0] OP_PP          = 5'd1;
  localparam logic [4:0] OP_SE          = 5'd5;
  localparam logic [4:0] OP_BE          = 5'd7;
  localparam logic [4:0] OP_POLL        = 5'd9;
  localparam logic [4:0] OP_RD_DUAL     = 5'd10;
  localparam logic [4:0] OP_RD_DUAL_DTR = 5'd11;
  localparam logic [4:0] OP_RD_QUAD     = 5'd12;
  localparam logic [4:0] OP_RD_QUAD_DTR = 5'd13;
  localparam logic [4:0] OP_RD_DUAL_4B  = 5'd14;
  localparam logic [4:0] OP_RD_QUAD_4B  = 5'd15;
  localparam logic [4:0] OP_PD          = 5'd16;
  localparam logic [4:0] OP_PD_REL      = 5'd17;

  // Data lane codes.
  localparam logic [1:0] LANES_NONE     = 2'd0;
  localparam logic [1:0] LANES_SERIAL   = 2'd1;
  localparam logic [1:0] LANES_PARALLEL = 2'd2;

  // Event codes.
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_DONE = 2'd1;
  localparam logic [1:0] EV_FAIL = 2'd2;

  // Status codes.
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BUSY     = 2'd1;
  localparam logic [1:0] ST_ADDR_ERR = 2'd2;
  localparam logic [1:0] ST_IF_ERR   = 2'd3;

  // Dummy byte counts for reads.
  localparam logic [2:0] DUMMY_NONE = 3'd0;
  localparam logic [2:0] DUMMY_TWO  = 3'd2;
  localparam logic [2:0] DUMMY_SEVEN = 3'd7;

  // Sequencer states.
  typedef enum logic [3:0] {
    S_IDLE,
    S_READ_WAIT,
    S_WR_EN,
    S_WR_START,
    S_WR_WAIT,
    S_ER_EN,
    S_ER_START,
    S_ER_WAIT,
    S_ERROR
  } seq_state_t;

  // One result item.
  typedef struct packed {
    logic        issue_valid;
    logic [4:0]  bus_op;
    logic [30:0] bus_address;
    logic        wide_address;
    logic [31:0] data_length;
    logic [2:0]  dummy_bytes;
    logic [1:0]  data_lanes;
    logic        ddr_on;
    logic [1:0]  event_res;
    logic [1:0]  status;
    logic [31:0] granted_length;
    logic [30:0] position_now;
  } result_t;

endpackage

[src/nor_flash_transaction_sequencer_top.sv]
// Top level of the NOR flash transaction sequencer: request decode, state and result queue.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall   cmd, request_length, request_address, bus_ok
//   out_     output     out_valid / out_stall one result per request
//   cfg_     input      cfg_valid / cfg_ready register index and write data
//
// Each request is decoded against the state registers and its result is written into a
// two-entry output queue at the accepting edge, so a new request is taken every cycle
// while the queue has room. in_stall rises only when both queue entries hold results
// that have not been taken. Reset (rst_n low, synchronous) returns the state to idle,
// the position to zero and the registers to their defaults; cfg_ready stays high.
`timescale 1ns / 1ps
module nor_flash_transaction_sequencer_top
  import nfts_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [3:0]  in_cmd,
  input  logic [31:0] in_request_length,
  input  logic [30:0] in_request_address,
  input  logic        in_bus_ok,
  // Result channel.
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_issue_valid,
  output logic [4:0]  out_bus_op,
  output logic [30:0] out_bus_address,
  output logic        out_wide_address,
  output logic [31:0] out_data_length,
  output logic [2:0]  out_dummy_bytes,
  output logic [1:0]  out_data_lanes,
  output logic        out_ddr_on,
  output logic [1:0]  out_event_res,
  output logic [1:0]  out_status,
  output logic [31:0] out_granted_length,
  output logic [30:0] out_position_now,
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [4:0]  cfg_data
);

  // Configuration registers.
  logic [4:0] cap_log2_r;
  logic       quad_r, dtr_r, shrink_r;

  // Sequencer state.
  seq_state_t  state_r, state_nxt;
  logic [30:0] pos_r, pos_nxt;
  logic [30:0] op_addr_r, op_addr_nxt;
  logic [31:0] left_r, left_nxt;
  logic [31:0] op_len_r, op_len_nxt;

  // Output queue.
  result_t    head_r, head_nxt, tail_r, tail_nxt, res;
  logic [1:0] count_r, count_nxt;

  logic push, pop;

  // Shared decode terms.
  logic        busy, refuse, ext, rd_wide, addr_in_range;
  logic [31:0] cap, avail, grant, page_avail, chunk;
  logic [32:0] pos_sum;
  logic [30:0] pos_adv;

  assign cfg_ready = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_log2_r <= CAP_LOG2_RST;
      quad_r     <= 1'b0;
      dtr_r      <= 1'b0;
      shrink_r   <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_CAP_LOG2: cap_log2_r <= cfg_data;
        CFG_QUAD:     quad_r     <= cfg_data[0];
        CFG_DTR:      dtr_r      <= cfg_data[0];
        CFG_SHRINK:   shrink_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Handshakes.
  assign in_stall  = (count_r == 2'd2);
  assign out_valid = (count_r != 2'd0);
  assign push      = in_valid && !in_stall;
  assign pop       = out_valid && !out_stall;

  // Capacity, clipping and address terms.
  assign cap           = 32'd1 << cap_log2_r;
  assign ext           = cap_log2_r > EXT_ADDR_LOG2;
  assign rd_wide       = ext && !shrink_r;
  assign busy          = (state_r != S_IDLE) && (state_r != S_ERROR);
  assign refuse        = busy && ((in_cmd <= 4'(CMD_SET_POS)) || (in_cmd == 4'(CMD_SUSPEND))
                                  || (in_cmd == 4'(CMD_RESUME)));
  assign avail         = ({1'b0, pos_r} < cap) ? (cap - {1'b0, pos_r}) : 32'd0;
  assign grant         = (in_request_length < avail) ? in_request_length : avail;
  assign addr_in_range = {1'b0, in_request_address} < cap;

  // Program chunks stop at the next page boundary.
  assign page_avail = PAGE_BYTES - ({1'b0, op_addr_r} & (PAGE_BYTES - 32'd1));
  assign chunk      = (page_avail < left_r) ? page_avail : left_r;

  // Position after a completed read or write, wrapping at capacity.
  assign pos_sum = {2'b00, pos_r} + {1'b0, op_len_r};
  assign pos_adv = (pos_sum == {1'b0, cap}) ? 31'd0 : pos_sum[30:0];

  // Next state of the sequencer.
  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    op_addr_nxt = op_addr_r;
    left_nxt    = left_r;
    op_len_nxt  = op_len_r;
    if (!refuse) begin
      unique case (in_cmd)
        CMD_READ: begin
          op_len_nxt  = grant;
          op_addr_nxt = 31'd0;
          left_nxt    = 32'd0;
          state_nxt   = S_READ_WAIT;
        end
        CMD_WRITE: begin
          op_len_nxt  = grant;
          left_nxt    = grant;
          op_addr_nxt = pos_r;
          state_nxt   = S_WR_EN;
        end
        CMD_ERASE_SEC, CMD_ERASE_BLK: begin
          if (addr_in_range) begin
            op_addr_nxt = in_request_address;
            left_nxt    = 32'd0;
            op_len_nxt  = (in_cmd == 4'(CMD_ERASE_SEC)) ? SECTOR_BYTES : BLOCK_BYTES;
            state_nxt   = S_ER_EN;
          end
        end
        CMD_SET_POS: begin
          if (addr_in_range) begin
            pos_nxt = in_request_address;
          end
        end
        CMD_BUS_DONE: begin
          if (busy && !in_bus_ok) begin
            state_nxt   = S_ERROR;
            op_addr_nxt = 31'd0;
            op_len_nxt  = 32'd0;
            left_nxt    = 32'd0;
          end else if (busy) begin
            unique case (state_r)
              S_READ_WAIT: begin
                state_nxt = S_IDLE;
                pos_nxt   = pos_adv;
              end
              S_WR_EN: begin
                left_nxt    = left_r - chunk;
                op_addr_nxt = op_addr_r + chunk[30:0];
                state_nxt   = S_WR_START;
              end
              S_WR_START: state_nxt = S_WR_WAIT;
              S_WR_WAIT: begin
                if (left_r != 32'd0) begin
                  state_nxt = S_WR_EN;
                end else begin
                  state_nxt = S_IDLE;
                  pos_nxt   = pos_adv;
                end
              end
              S_ER_EN:    state_nxt = S_ER_START;
              S_ER_START: state_nxt = S_ER_WAIT;
              S_ER_WAIT:  state_nxt = S_IDLE;
              default: ;
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // Result of the request.
  always_comb begin
    res              = '0;
    res.position_now = pos_nxt;
    if (refuse) begin
      res.status = ST_BUSY;
    end else begin
      unique case (in_cmd)
        CMD_READ: begin
          res.granted_length = grant;
          res.issue_valid    = 1'b1;
          res.bus_address    = pos_r;
          res.wide_address   = rd_wide;
          res.data_length    = grant;
          res.data_lanes     = LANES_PARALLEL;
          res.ddr_on         = dtr_r;
          if (rd_wide) begin
            res.bus_op      = quad_r ? OP_RD_QUAD_4B : OP_RD_DUAL_4B;
            res.dummy_bytes = quad_r ? DUMMY_TWO : DUMMY_NONE;
          end else if (quad_r) begin
            res.bus_op      = dtr_r ? OP_RD_QUAD_DTR : OP_RD_QUAD;
            res.dummy_bytes = dtr_r ? DUMMY_SEVEN : DUMMY_TWO;
          end else begin
            res.bus_op      = dtr_r ? OP_RD_DUAL_DTR : OP_RD_DUAL;
            res.dummy_bytes = dtr_r ? DUMMY_TWO : DUMMY_NONE;
          end
        end
        CMD_WRITE: begin
          res.granted_length = grant;
          res.issue_valid    = 1'b1;
          res.bus_op         = OP_WREN;
        end
        CMD_ERASE_SEC, CMD_ERASE_BLK: begin
          if (addr_in_range) begin
            res.status      = ST_BUSY;
            res.issue_valid = 1'b1;
            res.bus_op      = OP_WREN;
          end else begin
            res.status = ST_ADDR_ERR;
          end
        end
        CMD_SET_POS: begin
          if (!addr_in_range) begin
            res.status = ST_ADDR_ERR;
          end
        end
        CMD_SUSPEND: begin
          res.issue_valid = 1'b1;
          res.bus_op      = OP_PD;
        end
        CMD_RESUME: begin
          res.issue_valid = 1'b1;
          res.bus_op      = OP_PD_REL;
        end
        CMD_BUS_DONE: begin
          if (busy && !in_bus_ok) begin
            res.event_res = EV_FAIL;
          end else if (busy) begin
            unique case (state_r)
              S_READ_WAIT, S_ER_WAIT: res.event_res = EV_DONE;
              S_WR_EN: begin
                res.issue_valid  = 1'b1;
                res.bus_op       = (ext ? OP_PP + 5'd2 : OP_PP) + {4'd0, quad_r};
                res.bus_address  = op_addr_r;
                res.wide_address = ext;
                res.data_length  = chunk;
                res.data_lanes   = quad_r ? LANES_PARALLEL : LANES_SERIAL;
              end
              S_WR_START, S_ER_START: begin
                res.issue_valid = 1'b1;
                res.bus_op      = OP_POLL;
                res.data_lanes  = LANES_SERIAL;
              end
              S_WR_WAIT: begin
                if (left_r != 32'd0) begin
                  res.issue_valid = 1'b1;
                  res.bus_op      = OP_WREN;
                end else begin
                  res.event_res = EV_DONE;
                end
              end
              S_ER_EN: begin
                res.issue_valid  = 1'b1;
                res.bus_op       = ((op_len_r == SECTOR_BYTES) ? OP_SE : OP_BE)
                                   + {4'd0, ext};
                res.bus_address  = op_addr_r;
                res.wide_address = ext;
              end
              default: ;
            endcase
          end
          res.status = (state_nxt == S_ERROR) ? ST_IF_ERR :
                       (state_nxt == S_IDLE)  ? ST_OK : ST_BUSY;
        end
        default: begin
          res.status = (state_nxt == S_ERROR) ? ST_IF_ERR :
                       (state_nxt == S_IDLE)  ? ST_OK : ST_BUSY;
        end
      endcase
    end
  end

  // Sequencer registers update on each accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pos_r     <= '0;
      op_addr_r <= '0;
      left_r    <= '0;
      op_len_r  <= '0;
    end else if (push) begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      op_addr_r <= op_addr_nxt;
      left_r    <= left_nxt;
      op_len_r  <= op_len_nxt;
    end
  end

  // Two-entry result queue: head drives the outputs, tail catches a result behind it.
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (push && pop) begin
      if (count_r == 2'd1) begin
        head_nxt = res;
      end else begin
        head_nxt = tail_r;
        tail_nxt = res;
      end
    end else if (pop) begin
      head_nxt  = tail_r;
      count_nxt = count_r - 2'd1;
    end else if (push) begin
      if (count_r == 2'd0) begin
        head_nxt = res;
      end else begin
        tail_nxt = res;
      end
      count_nxt = count_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 2'd0;
    end else begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  // Result ports.
  assign out_issue_valid    = head_r.issue_valid;
  assign out_bus_op         = head_r.bus_op;
  assign out_bus_address    = head_r.bus_address;
  assign out_wide_address   = head_r.wide_address;
  assign out_data_length    = head_r.data_length;
  assign out_dummy_bytes    = head_r.dummy_bytes;
  assign out_data_lanes     = head_r.data_lanes;
  assign out_ddr_on         = head_r.ddr_on;
  assign out_event_res      = head_r.event_res;
  assign out_status         = head_r.status;
  assign out_granted_length = head_r.granted_length;
  assign out_position_now   = head_r.position_now;

endmodule

[sim/tb_top.sv]
// Self-checking testbench for the NOR flash transaction sequencer top level.
`timescale 1ns / 1ps
module tb_top;
  import nfts_pkg::*;

  // Descriptor and command codes that the package does not name.
  localparam logic [4:0] OP_PP_QUAD    = 5'd2;
  localparam logic [4:0] OP_PP_4B      = 5'd3;
  localparam logic [4:0] OP_PP_QUAD_4B = 5'd4;
  localparam logic [4:0] OP_SE_4B      = 5'd6;
  localparam logic [4:0] OP_BE_4B      = 5'd8;
  localparam logic [3:0] CMD_RESERVED  = 4'd15;

  localparam int CYCLE_LIMIT     = 400_000;
  localparam int ITEMS_PER_PHASE = 185;
  localparam int PHASES          = 8;
  localparam int HOLD_CYCLES     = 300;
  localparam int FAIL_AFTER      = 40;

  // Predicts every result of the sequencer and checks the block's results in order.
  class flash_seq_checker;
    logic [4:0]  cap_log2;
    logic        quad_io;
    logic        dtr_io;
    logic        shrink_rd;
    seq_state_t  state;
    logic [30:0] position;
    logic [30:0] op_addr;
    logic [31:0] left_bytes;
    logic [31:0] op_len;
    result_t     step_res;
    result_t     awaited_results[$];
    int          mismatches;

    function new();
      cap_log2   = CAP_LOG2_RST;
      quad_io    = 1'b0;
      dtr_io     = 1'b0;
      shrink_rd  = 1'b0;
      state      = S_IDLE;
      position   = '0;
      op_addr    = '0;
      left_bytes = '0;
      op_len     = '0;
      mismatches = 0;
    endfunction

    function void write_config(cfg_idx_t idx, logic [4:0] data);
      case (idx)
        CFG_CAP_LOG2: cap_log2 = data;
        CFG_QUAD: quad_io = data[0];
        CFG_DTR: dtr_io = data[0];
        CFG_SHRINK: shrink_rd = data[0];
        default: ;
      endcase
    endfunction

    function bit [63:0] cap_bytes();
      return 64'd1 << cap_log2;
    endfunction

    function bit extended();
      return cap_log2 > EXT_ADDR_LOG2;
    endfunction

    function bit busy();
      return state != S_IDLE && state != S_ERROR;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function logic [1:0] state_status();
      if (state == S_ERROR) return ST_IF_ERR;
      return busy() ? ST_BUSY : ST_OK;
    endfunction

    function void set_desc(logic [4:0] op, logic [30:0] addr, logic wide, logic [31:0] len,
                           logic [2:0] dummy, logic [1:0] lanes, logic ddr);
      step_res.issue_valid  = 1'b1;
      step_res.bus_op       = op;
      step_res.bus_address  = addr;
      step_res.wide_address = wide;
      step_res.data_length  = len;
      step_res.dummy_bytes  = dummy;
      step_res.data_lanes   = lanes;
      step_res.ddr_on       = ddr;
    endfunction

    // Length granted: the request cut to the room left up to the end of the device.
    function logic [31:0] clip_length(logic [31:0] req);
      bit [63:0] cap;
      bit [63:0] avail;
      cap   = cap_bytes();
      avail = (position < cap) ? cap - position : 64'd0;
      return (req < avail) ? req : avail[31:0];
    endfunction

    function void advance_position();
      bit [63:0] reach;
      reach = position;
      reach = reach + op_len;
      if (reach == cap_bytes()) reach = 0;
      position = reach[30:0];
    endfunction

    // Read opcode, dummy count and address width follow the mode registers.
    function void issue_read();
      logic       wide;
      logic [4:0] op;
      logic [2:0] dummy;
      wide = extended() && !shrink_rd;
      if (wide) begin
        op    = quad_io ? OP_RD_QUAD_4B : OP_RD_DUAL_4B;
        dummy = quad_io ? DUMMY_TWO : DUMMY_NONE;
      end else if (quad_io) begin
        op    = dtr_io ? OP_RD_QUAD_DTR : OP_RD_QUAD;
        dummy = dtr_io ? DUMMY_SEVEN : DUMMY_TWO;
      end else begin
        op    = dtr_io ? OP_RD_DUAL_DTR : OP_RD_DUAL;
        dummy = dtr_io ? DUMMY_TWO : DUMMY_NONE;
      end
      set_desc(op, position, wide, op_len, dummy, LANES_PARALLEL, dtr_io);
    endfunction

    // A finished bus transfer moves the running operation one step on.
    function void apply_bus_done(logic ok);
      logic [31:0] room;
      logic [31:0] chunk;
      logic [4:0]  op;
      if (!busy()) return;
      if (!ok) begin
        state      = S_ERROR;
        op_addr    = '0;
        op_len     = '0;
        left_bytes = '0;
        step_res.event_res = EV_FAIL;
        return;
      end
      case (state)
        S_READ_WAIT: begin
          state = S_IDLE;
          step_res.event_res = EV_DONE;
          advance_position();
        end
        S_WR_EN: begin
          // Program chunks never cross a page boundary.
          room  = PAGE_BYTES - ({1'b0, op_addr} & (PAGE_BYTES - 1));
          chunk = (room < left_bytes) ? room : left_bytes;
          if (extended()) op = quad_io ? OP_PP_QUAD_4B : OP_PP_4B;
          else op = quad_io ? OP_PP_QUAD : OP_PP;
          set_desc(op, op_addr, extended(), chunk, DUMMY_NONE,
                   quad_io ? LANES_PARALLEL : LANES_SERIAL, 1'b0);
          left_bytes = left_bytes - chunk;
          op_addr    = op_addr + chunk[30:0];
          state      = S_WR_START;
        end
        S_WR_START: begin
          state = S_WR_WAIT;
          set_desc(OP_POLL, '0, 1'b0, '0, DUMMY_NONE, LANES_SERIAL, 1'b0);
        end
        S_WR_WAIT: begin
          if (left_bytes != 0) begin
            state = S_WR_EN;
            set_desc(OP_WREN, '0, 1'b0, '0, DUMMY_NONE, LANES_NONE, 1'b0);
          end else begin
            state = S_IDLE;
            step_res.event_res = EV_DONE;
            advance_position();
          end
        end
        S_ER_EN: begin
          if (op_len == SECTOR_BYTES) op = extended() ? OP_SE_4B : OP_SE;
          else op = extended() ? OP_BE_4B : OP_BE;
          set_desc(op, op_addr, extended(), '0, DUMMY_NONE, LANES_NONE, 1'b0);
          state = S_ER_START;
        end
        S_ER_START: begin
          state = S_ER_WAIT;
          set_desc(OP_POLL, '0, 1'b0, '0, DUMMY_NONE, LANES_SERIAL, 1'b0);
        end
        S_ER_WAIT: begin
          state = S_IDLE;
          step_res.event_res = EV_DONE;
        end
        default: ;
      endcase
    endfunction

    // Works out the result of one accepted request and queues it.
    function void note_request(logic [3:0] cmd, logic [31:0] len, logic [30:0] addr,
                               logic ok);
      bit refused;
      step_res = '0;
      refused  = busy() && (cmd <= CMD_SET_POS || cmd == CMD_SUSPEND || cmd == CMD_RESUME);
      if (refused) begin
        step_res.status = ST_BUSY;
      end else begin
        case (cmd)
          CMD_READ: begin
            op_len     = clip_length(len);
            op_addr    = '0;
            left_bytes = '0;
            state      = S_READ_WAIT;
            step_res.granted_length = op_len;
            issue_read();
          end
          CMD_WRITE: begin
            op_len     = clip_length(len);
            left_bytes = op_len;
            op_addr    = position;
            state      = S_WR_EN;
            step_res.granted_length = op_len;
            set_desc(OP_WREN, '0, 1'b0, '0, DUMMY_NONE, LANES_NONE, 1'b0);
          end
          CMD_ERASE_SEC, CMD_ERASE_BLK: begin
            if (addr < cap_bytes()) begin
              op_addr    = addr;
              left_bytes = '0;
              op_len     = (cmd == CMD_ERASE_SEC) ? SECTOR_BYTES : BLOCK_BYTES;
              state      = S_ER_EN;
              step_res.status = ST_BUSY;
              set_desc(OP_WREN, '0, 1'b0, '0, DUMMY_NONE, LANES_NONE, 1'b0);
            end else begin
              step_res.status = ST_ADDR_ERR;
            end
          end
          CMD_SET_POS: begin
            if (addr < cap_bytes()) position = addr;
            else step_res.status = ST_ADDR_ERR;
          end
          CMD_SUSPEND: set_desc(OP_PD, '0, 1'b0, '0, DUMMY_NONE, LANES_NONE, 1'b0);
          CMD_RESUME: set_desc(OP_PD_REL, '0, 1'b0, '0, DUMMY_NONE, LANES_NONE, 1'b0);
          CMD_BUS_DONE: begin
            apply_bus_done(ok);
            step_res.status = state_status();
          end
          default: step_res.status = state_status();
        endcase
      end
      step_res.position_now = position;
      awaited_results.push_back(step_res);
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] seen);
      if (want !== seen) begin
        $error("%s: expected %0d, got %0d", name, want, seen);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (awaited_results.size() == 0) begin
        $error("result with no request waiting: bus_op %0d, status %0d",
               got.bus_op, got.status);
        mismatches++;
        return;
      end
      want = awaited_results.pop_front();
      compare_field("issue_valid", want.issue_valid, got.issue_valid);
      compare_field("bus_op", want.bus_op, got.bus_op);
      compare_field("bus_address", want.bus_address, got.bus_address);
      compare_field("wide_address", want.wide_address, got.wide_address);
      compare_field("data_length", want.data_length, got.data_length);
      compare_field("dummy_bytes", want.dummy_bytes, got.dummy_bytes);
      compare_field("data_lanes", want.data_lanes, got.data_lanes);
      compare_field("ddr_on", want.ddr_on, got.ddr_on);
      compare_field("event_res", want.event_res, got.event_res);
      compare_field("status", want.status, got.status);
      compare_field("granted_length", want.granted_length, got.granted_length);
      compare_field("position_now", want.position_now, got.position_now);
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [3:0]  in_cmd;
  logic [31:0] in_request_length;
  logic [30:0] in_request_address;
  logic        in_bus_ok;
  logic        out_valid;
  logic        out_stall;
  logic        out_issue_valid;
  logic [4:0]  out_bus_op;
  logic [30:0] out_bus_address;
  logic        out_wide_address;
  logic [31:0] out_data_length;
  logic [2:0]  out_dummy_bytes;
  logic [1:0]  out_data_lanes;
  logic        out_ddr_on;
  logic [1:0]  out_event_res;
  logic [1:0]  out_status;
  logic [31:0] out_granted_length;
  logic [30:0] out_position_now;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [2:0]  cfg_index;
  logic [4:0]  cfg_data;

  flash_seq_checker sb = new();
  int          gap_pct   = 0;
  int          stall_pct = 0;
  int          sent_count = 0;
  int          cycles = 0;
  int          hold_left = 0;
  logic        long_hold = 1'b0;

  // Register settings per phase; together they reach every read opcode.
  logic [4:0] cap_plan    [PHASES] = '{5'd24, 5'd21, 5'd31, 5'd25, 5'd24, 5'd22, 5'd30, 5'd28};
  logic       quad_plan   [PHASES] = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
  logic       dtr_plan    [PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1};
  logic       shrink_plan [PHASES] = '{1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0};

  nor_flash_transaction_sequencer_top u_top (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("nor_flash_transaction_sequencer_top regression: fail");
      $finish;
    end
  end

  // Result side: checks each taken result and drives the stall pattern.
  always @(posedge clk) begin : result_sink
    result_t got;
    got = {out_issue_valid, out_bus_op, out_bus_address, out_wide_address, out_data_length,
           out_dummy_bytes, out_data_lanes, out_ddr_on, out_event_res, out_status,
           out_granted_length, out_position_now};
    if (rst_n && out_valid && !out_stall) sb.check_result(got);
    if (long_hold) begin
      hold_left = HOLD_CYCLES;
      long_hold <= 1'b0;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Offers one request, with random idle cycles ahead of it, and notes it once taken.
  task automatic send_request(logic [3:0] cmd, logic [31:0] len, logic [30:0] addr,
                              logic ok);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid           <= 1'b1;
    in_cmd             <= cmd;
    in_request_length  <= len;
    in_request_address <= addr;
    in_bus_ok          <= ok;
    do @(posedge clk); while (in_stall);
    sb.note_request(cmd, len, addr, ok);
    sent_count++;
  endtask

  task automatic send_noise();
    send_request(4'($urandom_range(0, 15)), $urandom(), 31'($urandom()),
                 1'($urandom_range(0, 1)));
  endtask

  // Drives bus completions, mixed with noise, until the operation ends; long ones end in a failure.
  task automatic run_operation();
    int steps;
    steps = 0;
    while (sb.busy()) begin
      if ($urandom_range(0, 9) == 0) begin
        send_noise();
      end else begin
        send_request(CMD_BUS_DONE, $urandom(), 31'($urandom()),
                     steps < FAIL_AFTER && $urandom_range(0, 39) != 0);
        steps++;
      end
    end
  endtask

  function automatic logic [31:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return $urandom_range(0, 700);
    if (r < 70) return $urandom_range(0, 16);
    if (r < 85) return PAGE_BYTES * $urandom_range(1, 3);
    return $urandom();
  endfunction

  // Addresses mostly inside the device, some near its end or a page end, some anywhere.
  function automatic logic [30:0] pick_address();
    bit [63:0]   cap;
    int unsigned r;
    logic [30:0] a;
    cap = sb.cap_bytes();
    r   = $urandom_range(0, 99);
    a   = 31'($urandom());
    if (r < 15) return a;
    if (r < 30) return 31'(cap - $urandom_range(1, 700));
    if (r < 45) return 31'(a & (cap - 1) | 64'hF0);
    return 31'(a & (cap - 1));
  endfunction

  task automatic random_sequence();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 25) begin
      send_request(CMD_READ, pick_length(), 31'($urandom()), 1'($urandom_range(0, 1)));
    end else if (r < 55) begin
      send_request(CMD_WRITE, pick_length(), 31'($urandom()), 1'($urandom_range(0, 1)));
    end else if (r < 70) begin
      send_request(r < 62 ? CMD_ERASE_SEC : CMD_ERASE_BLK, $urandom(), pick_address(),
                   1'($urandom_range(0, 1)));
    end else if (r < 80) begin
      send_request(CMD_SET_POS, $urandom(), pick_address(), 1'($urandom_range(0, 1)));
    end else if (r < 90) begin
      send_request(r < 83 ? CMD_SUSPEND : (r < 86 ? CMD_RESUME : CMD_STATUS),
                   $urandom(), 31'($urandom()), 1'($urandom_range(0, 1)));
    end else begin
      send_noise();
    end
    run_operation();
  endtask

  // Writes all four registers; only called with no result pending, though a write may be in progress.
  task automatic write_settings(int phase);
    logic [4:0] vals [4];
    vals[0] = cap_plan[phase];
    vals[1] = {4'($urandom()), quad_plan[phase]};
    vals[2] = {4'($urandom()), dtr_plan[phase]};
    vals[3] = {4'($urandom()), shrink_plan[phase]};
    for (int i = 0; i < 4; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= 3'(i);
      cfg_data  <= vals[i];
      do @(posedge clk); while (!cfg_ready);
      sb.write_config(cfg_idx_t'(i), vals[i]);
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Directed opening on the reset settings (16 MiB device).
  task automatic directed_checks();
    send_request(CMD_STATUS, '0, '0, 1'b0);
    // Zero-length read, then a read clipped to the last byte that wraps the position.
    send_request(CMD_READ, '0, '0, 1'b0);
    send_request(CMD_BUS_DONE, '0, '0, 1'b1);
    send_request(CMD_SET_POS, '0, 31'h00FF_FFFF, 1'b0);
    send_request(CMD_READ, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1);
    send_request(CMD_BUS_DONE, 32'h8000_0000, '0, 1'b1);
    // A write that crosses a page boundary, with requests refused while it runs.
    send_request(CMD_SET_POS, '0, 31'd250, 1'b0);
    send_request(CMD_WRITE, 32'd10, '0, 1'b0);
    send_request(CMD_BUS_DONE, '0, '0, 1'b1);
    send_request(CMD_READ, 32'd5, '0, 1'b0);
    send_request(CMD_SUSPEND, '0, '0, 1'b0);
    repeat (5) send_request(CMD_BUS_DONE, '0, '0, 1'b1);
    // Addresses beyond the device.
    send_request(CMD_ERASE_SEC, '0, 31'h7FFF_FFFF, 1'b0);
    send_request(CMD_SET_POS, '0, 31'h7FFF_FFFF, 1'b0);
    // Failed erase, then a stray completion and a reserved command in the error state.
    send_request(CMD_ERASE_BLK, '0, '0, 1'b0);
    send_request(CMD_BUS_DONE, '0, '0, 1'b0);
    send_request(CMD_BUS_DONE, '0, '0, 1'b1);
    send_request(CMD_RESERVED, '0, '0, 1'b0);
    send_request(CMD_SUSPEND, '0, '0, 1'b0);
    send_request(CMD_RESUME, '0, '0, 1'b0);
  endtask

  // Main sequence: reset, directed checks, then random phases under different settings.
  initial begin
    int target;
    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_cmd             <= CMD_STATUS;
    in_request_length  <= '0;
    in_request_address <= '0;
    in_bus_ok          <= 1'b0;
    out_stall          <= 1'b0;
    cfg_valid          <= 1'b0;
    cfg_index          <= CFG_CAP_LOG2;
    cfg_data           <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    directed_checks();
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) write_settings(phase);
      case (phase % 4)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 64; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 64; end
        default: begin gap_pct = 35; stall_pct = 35; end
      endcase
      // Long receiver hold while requests keep coming, so the result queue fills.
      if (phase == 4) long_hold <= 1'b1;
      // Finish an operation left open across the settings change.
      run_operation();
      target = sent_count + ITEMS_PER_PHASE;
      while (sent_count < target) random_sequence();
      // Leave a write in progress so the next settings apply to its later descriptors.
      if (phase % 2 == 1) begin
        send_request(CMD_WRITE, 32'd600, '0, 1'b0);
        send_request(CMD_BUS_DONE, '0, '0, 1'b1);
      end
      drain();
    end
    repeat (8) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("nor_flash_transaction_sequencer_top regression: pass");
    end else begin
      $display("nor_flash_transaction_sequencer_top regression: fail");
    end
    $finish;
  end

endmodule
